[sv/mmpbs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mmpbs_pkg
// shared types and constants of the wildcard byte signature scanner
// ----------------------------------------------------------------------------
package mmpbs_pkg;

  // defaults of the top level parameters
  localparam int MAX_PATTERN_BYTES_DEF = 8;
  localparam int PATTERN_SLOTS_DEF     = 2;
  localparam int OFFSET_BITS_DEF       = 32;

  // slots and pattern bytes that have register bits
  localparam int CFG_SLOTS = 2;
  localparam int CFG_BYTES = 8;

  // configuration port
  localparam int PADDR_BITS   = 6;
  localparam int PDATA_BITS   = 64;
  localparam int REG_IDX_BITS = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_REGION_BASE      = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_BYTES_A  = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_BYTES_B  = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_WILDCARD_BITS_A  = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_WILDCARD_BITS_B  = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_LENGTH_A = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_LENGTH_B = 3'd6;
  localparam logic [REG_IDX_BITS-1:0] REG_SLOT_ENABLE      = 3'd7;

  typedef struct packed {
    logic [63:0]                 region_base;
    logic [CFG_SLOTS-1:0][63:0]  pattern_bytes;
    logic [CFG_SLOTS-1:0][7:0]   wildcard_bits;
    logic [CFG_SLOTS-1:0][3:0]   pattern_length;
    logic [CFG_SLOTS-1:0]        slot_enable;
  } cfg_t;

  // window tap control
  typedef struct packed {
    logic shift;
    logic clear;
  } tap_ctrl_t;

endpackage
`default_nettype wire

[sv/mmpbs_ifs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mmpbs_ifs
// valid/ready channels of the scanner: region bytes in, reports out
// ----------------------------------------------------------------------------
interface mmpbs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface mmpbs_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] match_address;
  logic        pattern_slot;
  logic        is_match;
  logic        last_of_run;

  modport source (output valid, output match_address, output pattern_slot,
                  output is_match, output last_of_run, input ready);
  modport sink   (input valid, input match_address, input pattern_slot,
                  input is_match, input last_of_run, output ready);
endinterface
`default_nettype wire

[sv/masked_multi_pattern_byte_scanner_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// masked_multi_pattern_byte_scanner_top
// wildcard byte signature scanner over a streamed byte region
// ----------------------------------------------------------------------------
// The block takes one region byte per request on the scan channel and keeps
// the last MAX_PATTERN_BYTES bytes in a row of window taps; each tap compares
// its byte against the pattern byte of its position for every slot, so a whole
// start position is judged at once. A non-final byte is accepted, then judged,
// then sends one report per match; reports leave through an output register,
// so a waiting report does not hold off the judge. On the final byte the window
// is shifted out one tap at a time: every remaining start position is judged
// and its reports are sent, and then the end marker (is_match 0, address one
// past the last byte) follows. Reports come in start order, slot order inside
// a position, with last_of_run on the last report of a byte. Registers are
// written over the apb port at 8*index and are to be written while the block is
// idle.
// ----------------------------------------------------------------------------
module masked_multi_pattern_byte_scanner_top
  import mmpbs_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
  parameter int PATTERN_SLOTS     = PATTERN_SLOTS_DEF,
  parameter int OFFSET_BITS       = OFFSET_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready,
  mmpbs_byte_if.sink            scan,
  mmpbs_result_if.source        report
);

  // count width holds MAX_PATTERN_BYTES itself
  localparam int LW = $clog2(MAX_PATTERN_BYTES + 1);
  // compare width for lengths against counts and positions
  localparam int CW = (LW > 4) ? LW : 4;
  localparam int SW = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_JUDGE,
    ST_EMIT,
    ST_END
  } state_t;

  cfg_t   cfg;
  state_t state;

  // window row, tap 0 holds the oldest byte
  logic [7:0]                     tap_byte  [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0]   tap_valid;
  logic [PATTERN_SLOTS-1:0]       tap_hit   [MAX_PATTERN_BYTES];
  logic [PATTERN_SLOTS-1:0][7:0]  tap_want  [MAX_PATTERN_BYTES];
  logic [PATTERN_SLOTS-1:0]       tap_care  [MAX_PATTERN_BYTES];
  tap_ctrl_t                      tap_ctrl;

  logic [CW-1:0]                  lenc      [PATTERN_SLOTS];
  logic [PATTERN_SLOTS-1:0]       slot_live;
  logic [PATTERN_SLOTS-1:0]       all_hit;
  logic [PATTERN_SLOTS-1:0]       judge_mask;

  // scan state
  logic [LW-1:0]                  vcount;       // valid taps in the window
  logic [LW-1:0]                  vcount_drop;
  logic [LW-1:0]                  vcount_inc;
  logic [OFFSET_BITS-1:0]         offset;       // offset of the next byte
  logic [OFFSET_BITS-1:0]         judge_off;
  logic                           fin_run;      // current byte ends the region
  logic [PATTERN_SLOTS-1:0]       pend;
  logic [PATTERN_SLOTS-1:0]       rest;
  logic [SW-1:0]                  pick_idx;
  logic                           found;

  // handshake helpers
  logic                           accept;
  logic                           out_free;
  logic                           adv;
  logic                           flush_shift;

  // output register
  logic                           out_valid;
  logic [63:0]                    out_address;
  logic                           out_slot;
  logic                           out_is_match;
  logic                           out_last;

  mmpbs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // per slot: clamped length and whether the slot can match at all
  for (genvar s = 0; s < PATTERN_SLOTS; s++) begin : g_slot
    if (s < CFG_SLOTS) begin : g_cfg
      logic [CW-1:0] len_w;
      logic [CW-1:0] lim;
      assign len_w        = CW'(cfg.pattern_length[s]);
      assign lim          = CW'(MAX_PATTERN_BYTES);
      assign lenc[s]      = (len_w > lim) ? lim : len_w;
      assign slot_live[s] = cfg.slot_enable[s] && (lenc[s] <= CW'(vcount));
    end else begin : g_none
      // slots without registers never match
      assign lenc[s]      = '0;
      assign slot_live[s] = 1'b0;
    end
  end

  // pattern byte and care bit for every tap position and slot
  for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_pat
    for (genvar s = 0; s < PATTERN_SLOTS; s++) begin : g_ps
      if (s < CFG_SLOTS && j < CFG_BYTES) begin : g_reg
        assign tap_want[j][s] = cfg.pattern_bytes[s][8*j +: 8];
        assign tap_care[j][s] = (CW'(j) < lenc[s]) && !cfg.wildcard_bits[s][j];
      end else if (s < CFG_SLOTS) begin : g_zero
        // bytes past the register compare against zero, no wildcard
        assign tap_want[j][s] = 8'h00;
        assign tap_care[j][s] = CW'(j) < lenc[s];
      end else begin : g_off
        assign tap_want[j][s] = 8'h00;
        assign tap_care[j][s] = 1'b0;
      end
    end
  end

  // the row of taps, new bytes enter at the top and move toward tap 0
  for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_tap
    logic [7:0] nb_byte;
    logic       nb_valid;
    if (j == MAX_PATTERN_BYTES - 1) begin : g_top
      assign nb_byte  = scan.data_byte;
      assign nb_valid = accept;
    end else begin : g_mid
      assign nb_byte  = tap_byte[j+1];
      assign nb_valid = tap_valid[j+1];
    end

    mmpbs_tap #(
      .SLOTS (PATTERN_SLOTS)
    ) u_tap (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (tap_ctrl),
      .byte_in  (nb_byte),
      .valid_in (nb_valid),
      .want     (tap_want[j]),
      .care     (tap_care[j]),
      .byte_q   (tap_byte[j]),
      .valid_q  (tap_valid[j]),
      .hit      (tap_hit[j])
    );
  end

  // judge the start at tap 0, only when that tap holds a region byte
  always_comb begin
    all_hit = '1;
    for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
      all_hit = all_hit & tap_hit[j];
    end
    judge_mask = all_hit & slot_live & {PATTERN_SLOTS{tap_valid[0]}};
  end

  // lowest pending slot goes out first
  always_comb begin
    pick_idx = '0;
    found    = 1'b0;
    for (int s = 0; s < PATTERN_SLOTS; s++) begin
      if (pend[s] && !found) begin
        pick_idx = SW'(s);
        found    = 1'b1;
      end
    end
    rest = pend & (pend - PATTERN_SLOTS'(1));
  end

  assign vcount_inc  = (vcount == LW'(MAX_PATTERN_BYTES)) ? vcount : vcount + LW'(1);
  assign vcount_drop = vcount - LW'(tap_valid[0]);

  assign out_free    = !out_valid || report.ready;
  assign scan.ready  = (state == ST_IDLE);
  assign accept      = scan.valid && scan.ready;

  // done with the position at tap 0
  assign adv = ((state == ST_JUDGE) && (judge_mask == '0)) ||
               ((state == ST_EMIT) && out_free && (rest == '0));
  // flush: move the next start position into tap 0
  assign flush_shift = adv && fin_run;

  assign tap_ctrl.shift = accept || flush_shift;
  assign tap_ctrl.clear = (state == ST_END) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      vcount    <= '0;
      offset    <= '0;
      fin_run   <= 1'b0;
      pend      <= '0;
    end else begin
      // a report taken this cycle empties the register unless a new one loads
      if (out_valid && report.ready && (state != ST_EMIT) && (state != ST_END)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            vcount  <= vcount_inc;
            offset  <= offset + OFFSET_BITS'(1);
            fin_run <= scan.final_byte;
            state   <= ST_JUDGE;
          end
        end
        ST_JUDGE: begin
          pend      <= judge_mask;
          judge_off <= offset - OFFSET_BITS'(vcount);
          if (judge_mask != '0) begin
            state <= ST_EMIT;
          end else if (!fin_run) begin
            state <= ST_IDLE;
          end else begin
            vcount <= vcount_drop;
            state  <= (vcount_drop == '0) ? ST_END : ST_JUDGE;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            out_address  <= cfg.region_base + 64'(judge_off);
            out_slot     <= pick_idx[0];
            out_is_match <= 1'b1;
            out_last     <= !fin_run && (rest == '0);
            pend         <= rest;
            if (rest == '0) begin
              if (!fin_run) begin
                state <= ST_IDLE;
              end else begin
                vcount <= vcount_drop;
                state  <= (vcount_drop == '0) ? ST_END : ST_JUDGE;
              end
            end
          end
        end
        ST_END: begin
          // end marker points one past the last byte, then a new region starts
          if (out_free) begin
            out_valid    <= 1'b1;
            out_address  <= cfg.region_base + 64'(offset);
            out_slot     <= 1'b0;
            out_is_match <= 1'b0;
            out_last     <= 1'b1;
            offset       <= '0;
            fin_run      <= 1'b0;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign report.valid         = out_valid;
  assign report.match_address = out_address;
  assign report.pattern_slot  = out_slot;
  assign report.is_match      = out_is_match;
  assign report.last_of_run   = out_last;

`ifndef SYNTHESIS
  // an accepted byte is judged in the next cycle
  a_accept_judge: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_JUDGE)
    else $error("accepted byte not judged next");

  // the valid count follows the valid taps of the window
  a_vcount_taps: assert property (@(posedge clk) disable iff (rst)
    $countones(tap_valid) == int'(vcount))
    else $error("valid count out of step with window taps");

  // no report is left pending when a new byte may come in
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> pend == '0)
    else $error("pending reports while idle");

  // the end marker restarts the region
  a_end_restart: assert property (@(posedge clk) disable iff (rst)
    (state == ST_END) && out_free |=> (offset == '0) && (vcount == '0) && !fin_run)
    else $error("region state not cleared after end marker");
`endif

endmodule
`default_nettype wire

[sv/mmpbs_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mmpbs_regs
// apb register file holding base address, patterns, wildcards, lengths and enables
// ----------------------------------------------------------------------------
module mmpbs_regs
  import mmpbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic                    wr;
  logic [REG_IDX_BITS-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[PADDR_BITS-1:PADDR_BITS-REG_IDX_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_REGION_BASE:      cfg.region_base       <= pwdata;
        REG_PATTERN_BYTES_A:  cfg.pattern_bytes[0]  <= pwdata;
        REG_PATTERN_BYTES_B:  cfg.pattern_bytes[1]  <= pwdata;
        REG_WILDCARD_BITS_A:  cfg.wildcard_bits[0]  <= pwdata[7:0];
        REG_WILDCARD_BITS_B:  cfg.wildcard_bits[1]  <= pwdata[7:0];
        REG_PATTERN_LENGTH_A: cfg.pattern_length[0] <= pwdata[3:0];
        REG_PATTERN_LENGTH_B: cfg.pattern_length[1] <= pwdata[3:0];
        REG_SLOT_ENABLE:      cfg.slot_enable       <= pwdata[CFG_SLOTS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_REGION_BASE:      prdata = cfg.region_base;
      REG_PATTERN_BYTES_A:  prdata = cfg.pattern_bytes[0];
      REG_PATTERN_BYTES_B:  prdata = cfg.pattern_bytes[1];
      REG_WILDCARD_BITS_A:  prdata = PDATA_BITS'(cfg.wildcard_bits[0]);
      REG_WILDCARD_BITS_B:  prdata = PDATA_BITS'(cfg.wildcard_bits[1]);
      REG_PATTERN_LENGTH_A: prdata = PDATA_BITS'(cfg.pattern_length[0]);
      REG_PATTERN_LENGTH_B: prdata = PDATA_BITS'(cfg.pattern_length[1]);
      REG_SLOT_ENABLE:      prdata = PDATA_BITS'(cfg.slot_enable);
      default:              prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[sv/mmpbs_tap.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mmpbs_tap
// one window position: holds a byte, passes it down, compares per slot
// ----------------------------------------------------------------------------
module mmpbs_tap
  import mmpbs_pkg::*;
#(
  parameter int SLOTS = PATTERN_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tap_ctrl_t             ctrl,
  input  logic [7:0]            byte_in,
  input  logic                  valid_in,
  input  logic [SLOTS-1:0][7:0] want,
  input  logic [SLOTS-1:0]      care,
  output logic [7:0]            byte_q,
  output logic                  valid_q,
  output logic [SLOTS-1:0]      hit
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (ctrl.clear) begin
      valid_q <= 1'b0;
    end else if (ctrl.shift) begin
      valid_q <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      byte_q <= byte_in;
    end
  end

  // a position that does not care always passes
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      hit[s] = !care[s] || (byte_q == want[s]);
    end
  end

endmodule
`default_nettype wire
